// File: sv/psnd_pkg.sv
// Shared definitions for the point-to-segment nearest point and distance block.
// Holds the default coordinate width and the clamp status codes.
// Used by the top level and its checker.
`default_nettype none

package psnd_pkg;

  localparam int unsigned COORD_BITS_DEF = 24;

  typedef enum logic [1:0] {
    ST_INTERIOR = 2'd0,
    ST_START    = 2'd1,
    ST_END      = 2'd2,
    ST_DEGEN    = 2'd3
  } clamp_e;

endpackage

`default_nettype wire

// File: sv/psnd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with round half up.
// Quotient of num_i / den_i is known to stay below 2**COORD_BITS.
// Standalone; no package dependency.
`default_nettype none

module psnd_div #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    ce_i,
  input  wire logic                    valid_i,
  input  wire logic [3*COORD_BITS:0]   num_i,
  input  wire logic [2*COORD_BITS:0]   den_i,
  output logic                         valid_o,
  output logic [COORD_BITS-1:0]        quot_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned DW = 2 * C + 1;
  localparam int unsigned RW = 2 * C + 2;

  logic [DW-1:0] rem_q [0:C];
  logic [DW-1:0] den_q [0:C];
  logic [C-1:0]  low_q [0:C];
  logic [C-1:0]  quo_q [0:C];
  logic [C:0]    vld_q;

  logic [DW-1:0] rem_d [1:C];
  logic [C-1:0]  low_d [1:C];
  logic [C-1:0]  quo_d [1:C];

  logic [C-1:0]  quot_d;
  logic [C-1:0]  quot_q;
  logic          out_vld_q;

  always_comb begin
    logic [RW-1:0] shf;
    logic [RW-1:0] dif;
    logic          ge;
    for (int k = 0; k < C; k++) begin
      shf = {rem_q[k], low_q[k][C-1]};
      dif = shf - {1'b0, den_q[k]};
      ge  = (shf >= {1'b0, den_q[k]});
      rem_d[k+1] = ge ? dif[DW-1:0] : shf[DW-1:0];
      low_d[k+1] = {low_q[k][C-2:0], 1'b0};
      quo_d[k+1] = {quo_q[k][C-2:0], ge};
    end
  end

  always_comb begin
    logic rnd;
    rnd    = ({rem_q[C], 1'b0} >= {1'b0, den_q[C]});
    quot_d = quo_q[C] + {{(C-1){1'b0}}, rnd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (ce_i) begin
      vld_q     <= {vld_q[C-1:0], valid_i};
      out_vld_q <= vld_q[C];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0] <= num_i[3*C:C];
      low_q[0] <= num_i[C-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      for (int k = 1; k <= C; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_q[k-1];
      end
      quot_q <= quot_d;
    end
  end

  assign valid_o = out_vld_q;
  assign quot_o  = quot_q;

endmodule

`default_nettype wire

// File: sv/psnd_sqrt.sv
// Pipelined integer square root, one root bit per stage (digit-by-digit).
// Returns floor(sqrt(radicand_i)) for a radicand of 2*COORD_BITS+1 bits.
// Standalone; no package dependency.
`default_nettype none

module psnd_sqrt #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    ce_i,
  input  wire logic                    valid_i,
  input  wire logic [2*COORD_BITS:0]   radicand_i,
  output logic                         valid_o,
  output logic [COORD_BITS:0]          root_o
);

  localparam int unsigned RB   = COORD_BITS + 1;
  localparam int unsigned RADW = 2 * RB;
  localparam int unsigned REMW = RB + 3;

  logic [REMW-1:0] rem_q  [0:RB];
  logic [RB-1:0]   root_q [0:RB];
  logic [RADW-1:0] rad_q  [0:RB];
  logic [RB:0]     vld_q;

  logic [REMW-1:0] rem_d  [1:RB];
  logic [RB-1:0]   root_d [1:RB];
  logic [RADW-1:0] rad_d  [1:RB];

  always_comb begin
    logic [REMW-1:0] cur;
    logic [REMW-1:0] trial;
    logic            ge;
    for (int k = 0; k < RB; k++) begin
      cur   = {rem_q[k][REMW-3:0], rad_q[k][RADW-1:RADW-2]};
      trial = {1'b0, root_q[k], 2'b01};
      ge    = (cur >= trial);
      rem_d[k+1]  = ge ? (cur - trial) : cur;
      root_d[k+1] = {root_q[k][RB-2:0], ge};
      rad_d[k+1]  = {rad_q[k][RADW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[RB-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rad_q[0]  <= {1'b0, radicand_i};
      for (int k = 1; k <= RB; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
    end
  end

  assign valid_o = vld_q[RB];
  assign root_o  = root_q[RB];

endmodule

`default_nettype wire

// File: sv/point_segment_nearest_distance_top.sv
// Throughput: one item per cycle while the skid entry is empty; the divider and square root units are fully pipelined.
// A two-entry output stage keeps accepting while a result waits; stalls only when both fill.
// Reset clears all valid bits and the output stage; payload registers are not reset.
// Depends on psnd_pkg, psnd_div and psnd_sqrt.
`default_nettype none

module point_segment_nearest_distance_top #(
  parameter int unsigned COORD_BITS = psnd_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_W  = ((6 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * COORD_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // query_x, query_y, start_x, start_y, end_x, end_y, zero pad
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // near_x, near_y, distance, zero pad
  output logic [OUT_W-1:0]       m_axis_tdata,
  // clamp_status
  output logic [1:0]             m_axis_tuser
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned LAT = C + 2;

  typedef struct packed {
    logic [C-1:0]     ax;
    logic [C-1:0]     ay;
    logic [C-1:0]     bx;
    logic [C-1:0]     by;
    logic [C-1:0]     qx;
    logic [C-1:0]     qy;
    logic             xneg;
    logic             yneg;
    psnd_pkg::clamp_e status;
  } dside_t;

  typedef struct packed {
    logic [C-1:0]     nx;
    logic [C-1:0]     ny;
    psnd_pkg::clamp_e status;
  } sside_t;

  logic ce;

  // stage 1: differences
  logic                v1_q;
  logic signed [C:0]   dx1_q, dy1_q, px1_q, py1_q;
  logic [C-1:0]        ax1_q, ay1_q, bx1_q, by1_q, qx1_q, qy1_q;

  // stage 2: products
  logic                  v2_q;
  logic signed [2*C+1:0] pdx2_q, pdy2_q, ddx2_q, ddy2_q;
  logic signed [C:0]     dx2_q, dy2_q;
  logic [C-1:0]          ax2_q, ay2_q, bx2_q, by2_q, qx2_q, qy2_q;

  // stage 3: dot and squared length
  logic                  v3_q;
  logic signed [2*C+1:0] dot3_q;
  logic [2*C:0]          len3_q;
  logic signed [C:0]     dx3_q, dy3_q;
  logic [C-1:0]          ax3_q, ay3_q, bx3_q, by3_q, qx3_q, qy3_q;

  // stage 4: clamp decision and partial products
  logic                  v4_q;
  logic [2*C-1:0]        lox4_q, loy4_q;
  logic [2*C:0]          hix4_q, hiy4_q;
  logic [2*C:0]          len4_q;
  dside_t                side4_q;

  // stage 5: numerators
  logic                  v5_q;
  logic [3*C:0]          numx5_q, numy5_q;
  logic [2*C:0]          len5_q;
  dside_t                side5_q;

  logic                  dvx_vld, dvy_vld;
  logic [C-1:0]          quox, quoy;
  dside_t                dline_q [0:LAT-1];

  // stage 6: nearest point and error
  logic                  v6_q;
  logic [C-1:0]          errx6_q, erry6_q;
  sside_t                side6_q;

  // stage 7: squares
  logic                  v7_q;
  logic [2*C-1:0]        sqx7_q, sqy7_q;
  sside_t                side7_q;

  // stage 8: radicand
  logic                  v8_q;
  logic [2*C:0]          rad8_q;
  sside_t                side8_q;

  logic                  sq_vld;
  logic [C:0]            root;
  sside_t                sline_q [0:LAT-1];

  // output stage
  logic                  out_v_q, skid_v_q;
  logic                  out_v_d, skid_v_d;
  logic [OUT_W-1:0]      out_data_q, skid_data_q, res_data;
  logic [1:0]            out_user_q, skid_user_q, res_user;

  assign ce            = !skid_v_q;
  assign s_axis_tready = ce;

  // stage 1
  always_ff @(posedge clk_i) begin
    if (ce) begin
      qx1_q <= s_axis_tdata[C-1:0];
      qy1_q <= s_axis_tdata[2*C-1:C];
      ax1_q <= s_axis_tdata[3*C-1:2*C];
      ay1_q <= s_axis_tdata[4*C-1:3*C];
      bx1_q <= s_axis_tdata[5*C-1:4*C];
      by1_q <= s_axis_tdata[6*C-1:5*C];
      dx1_q <= $signed({s_axis_tdata[5*C-1], s_axis_tdata[5*C-1:4*C]})
             - $signed({s_axis_tdata[3*C-1], s_axis_tdata[3*C-1:2*C]});
      dy1_q <= $signed({s_axis_tdata[6*C-1], s_axis_tdata[6*C-1:5*C]})
             - $signed({s_axis_tdata[4*C-1], s_axis_tdata[4*C-1:3*C]});
      px1_q <= $signed({s_axis_tdata[C-1], s_axis_tdata[C-1:0]})
             - $signed({s_axis_tdata[3*C-1], s_axis_tdata[3*C-1:2*C]});
      py1_q <= $signed({s_axis_tdata[2*C-1], s_axis_tdata[2*C-1:C]})
             - $signed({s_axis_tdata[4*C-1], s_axis_tdata[4*C-1:3*C]});
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (ce) begin
      pdx2_q <= px1_q * dx1_q;
      pdy2_q <= py1_q * dy1_q;
      ddx2_q <= dx1_q * dx1_q;
      ddy2_q <= dy1_q * dy1_q;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      bx2_q  <= bx1_q;
      by2_q  <= by1_q;
      qx2_q  <= qx1_q;
      qy2_q  <= qy1_q;
    end
  end

  // stage 3
  always_ff @(posedge clk_i) begin
    if (ce) begin
      dot3_q <= pdx2_q + pdy2_q;
      len3_q <= {1'b0, ddx2_q[2*C-1:0]} + {1'b0, ddy2_q[2*C-1:0]};
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      bx3_q  <= bx2_q;
      by3_q  <= by2_q;
      qx3_q  <= qx2_q;
      qy3_q  <= qy2_q;
    end
  end

  // stage 4
  psnd_pkg::clamp_e  status4;
  logic signed [C:0] negx4, negy4;
  logic [C-1:0]      magx4, magy4;
  logic [2*C:0]      dotu4;

  always_comb begin
    if (len3_q == '0) begin
      status4 = psnd_pkg::ST_DEGEN;
    end else if (dot3_q[2*C+1]) begin
      status4 = psnd_pkg::ST_START;
    end else if (dot3_q > $signed({1'b0, len3_q})) begin
      status4 = psnd_pkg::ST_END;
    end else begin
      status4 = psnd_pkg::ST_INTERIOR;
    end
    negx4 = -dx3_q;
    negy4 = -dy3_q;
    magx4 = dx3_q[C] ? negx4[C-1:0] : dx3_q[C-1:0];
    magy4 = dy3_q[C] ? negy4[C-1:0] : dy3_q[C-1:0];
    dotu4 = dot3_q[2*C:0];
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      lox4_q         <= dotu4[C-1:0] * magx4;
      loy4_q         <= dotu4[C-1:0] * magy4;
      hix4_q         <= dotu4[2*C:C] * magx4;
      hiy4_q         <= dotu4[2*C:C] * magy4;
      len4_q         <= len3_q;
      side4_q.ax     <= ax3_q;
      side4_q.ay     <= ay3_q;
      side4_q.bx     <= bx3_q;
      side4_q.by     <= by3_q;
      side4_q.qx     <= qx3_q;
      side4_q.qy     <= qy3_q;
      side4_q.xneg   <= dx3_q[C];
      side4_q.yneg   <= dy3_q[C];
      side4_q.status <= status4;
    end
  end

  // stage 5
  always_ff @(posedge clk_i) begin
    if (ce) begin
      numx5_q <= {hix4_q, {C{1'b0}}} + {{(C+1){1'b0}}, lox4_q};
      numy5_q <= {hiy4_q, {C{1'b0}}} + {{(C+1){1'b0}}, loy4_q};
      len5_q  <= len4_q;
      side5_q <= side4_q;
    end
  end

  psnd_div #(.COORD_BITS(C)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (v5_q),
    .num_i   (numx5_q),
    .den_i   (len5_q),
    .valid_o (dvx_vld),
    .quot_o  (quox)
  );

  psnd_div #(.COORD_BITS(C)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (v5_q),
    .num_i   (numy5_q),
    .den_i   (len5_q),
    .valid_o (dvy_vld),
    .quot_o  (quoy)
  );

  always_ff @(posedge clk_i) begin
    if (ce) begin
      dline_q[0] <= side5_q;
      for (int i = 1; i < LAT; i++) begin
        dline_q[i] <= dline_q[i-1];
      end
    end
  end

  // stage 6
  dside_t            ds6;
  logic signed [C:0] stpx6, stpy6, dfx6, dfy6, ndx6, ndy6;
  logic [C-1:0]      nx6, ny6;

  always_comb begin
    ds6   = dline_q[LAT-1];
    stpx6 = ds6.xneg ? ($signed({ds6.ax[C-1], ds6.ax}) - $signed({1'b0, quox}))
                     : ($signed({ds6.ax[C-1], ds6.ax}) + $signed({1'b0, quox}));
    stpy6 = ds6.yneg ? ($signed({ds6.ay[C-1], ds6.ay}) - $signed({1'b0, quoy}))
                     : ($signed({ds6.ay[C-1], ds6.ay}) + $signed({1'b0, quoy}));
    case (ds6.status)
      psnd_pkg::ST_INTERIOR: begin
        nx6 = stpx6[C-1:0];
        ny6 = stpy6[C-1:0];
      end
      psnd_pkg::ST_END: begin
        nx6 = ds6.bx;
        ny6 = ds6.by;
      end
      default: begin
        nx6 = ds6.ax;
        ny6 = ds6.ay;
      end
    endcase
    dfx6 = $signed({ds6.qx[C-1], ds6.qx}) - $signed({nx6[C-1], nx6});
    dfy6 = $signed({ds6.qy[C-1], ds6.qy}) - $signed({ny6[C-1], ny6});
    ndx6 = -dfx6;
    ndy6 = -dfy6;
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      errx6_q        <= dfx6[C] ? ndx6[C-1:0] : dfx6[C-1:0];
      erry6_q        <= dfy6[C] ? ndy6[C-1:0] : dfy6[C-1:0];
      side6_q.nx     <= nx6;
      side6_q.ny     <= ny6;
      side6_q.status <= ds6.status;
    end
  end

  // stages 7 and 8
  always_ff @(posedge clk_i) begin
    if (ce) begin
      sqx7_q  <= errx6_q * errx6_q;
      sqy7_q  <= erry6_q * erry6_q;
      side7_q <= side6_q;
      rad8_q  <= {1'b0, sqx7_q} + {1'b0, sqy7_q};
      side8_q <= side7_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (ce) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= dvx_vld & dvy_vld;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  psnd_sqrt #(.COORD_BITS(C)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ce_i       (ce),
    .valid_i    (v8_q),
    .radicand_i (rad8_q),
    .valid_o    (sq_vld),
    .root_o     (root)
  );

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sline_q[0] <= side8_q;
      for (int i = 1; i < LAT; i++) begin
        sline_q[i] <= sline_q[i-1];
      end
    end
  end

  // result packing
  always_comb begin
    res_data                  = '0;
    res_data[C-1:0]           = sline_q[LAT-1].nx;
    res_data[2*C-1:C]         = sline_q[LAT-1].ny;
    res_data[3*C+1:2*C]       = {1'b0, root};
    res_user                  = sline_q[LAT-1].status;
  end

  // output register with skid entry
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (out_v_q && m_axis_tready) begin
      out_v_d  = skid_v_q;
      skid_v_d = 1'b0;
    end
    if (sq_vld && ce) begin
      if (out_v_q && !m_axis_tready) begin
        skid_v_d = 1'b1;
      end else begin
        out_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_vld && ce) begin
      if (out_v_q && !m_axis_tready) begin
        skid_data_q <= res_data;
        skid_user_q <= res_user;
      end else begin
        out_data_q <= res_data;
        out_user_q <= res_user;
      end
    end else if (out_v_q && m_axis_tready && skid_v_q) begin
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

// File: sv/psnd_chk.sv
// Port-level checker for the point-to-segment nearest distance top level.
// Bound to the top level below; depends on psnd_pkg for the default width.
`default_nettype none

module psnd_chk #(
  parameter int unsigned COORD_BITS = psnd_pkg::COORD_BITS_DEF,
  localparam int unsigned OUT_W = ((3 * COORD_BITS + 2 + 7) / 8) * 8
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic [1:0]       m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  a_release_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> $past(m_axis_tvalid && m_axis_tready))
    else $error("input released without an output transfer");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3*COORD_BITS+1] == 1'b0)
    else $error("distance exceeds segment box bound");

endmodule

bind point_segment_nearest_distance_top psnd_chk #(.COORD_BITS(COORD_BITS)) u_psnd_chk (.*);

`default_nettype wire

// File: dv/tb_top.sv
// Testbench for point_segment_nearest_distance_top: streams point/segment queries and checks
// the nearest point, floor distance and clamp status against an in-bench predictor.
// Depends on psnd_pkg and the RTL of the block.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB    = psnd_pkg::COORD_BITS_DEF;
  localparam int IN_W  = ((6 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((3 * CB + 2 + 7) / 8) * 8;
  localparam int LAT   = 2 * CB + 12;
  localparam int N_RAND = 1900;
  localparam int LIMIT  = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t ey, ex, sy, sx, qy, qx;
  } query_t;
  typedef struct packed {
    logic [1:0] st;
    logic [CB+1:0] distance;
    coord_t ny, nx;
  } nearest_t;
  typedef struct {
    query_t q;
    logic has_exp;
    nearest_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  nearest_t nearest_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_rx = 1'b0;
  bit calm = 1'b0;

  point_segment_nearest_distance_top uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_axis(longint s, longint d, longint dot, longint len);
    logic [127:0] num, q, rem, mag;
    mag = (d < 0) ? -d : d;
    num = 128'(dot) * mag;
    q = num / 128'(len);
    rem = num % 128'(len);
    if (2 * rem >= 128'(len)) q++;
    return (d < 0) ? s - longint'(q) : s + longint'(q);
  endfunction

  function automatic nearest_t project_point(query_t q);
    nearest_t r;
    longint qx, qy, ax, ay, bx, by, dx, dy, dot, len, nx, ny, ex, ey;
    qx = q.qx; qy = q.qy; ax = q.sx; ay = q.sy; bx = q.ex; by = q.ey;
    dx = bx - ax; dy = by - ay;
    dot = (qx - ax) * dx + (qy - ay) * dy;
    len = dx * dx + dy * dy;
    if (len == 0) begin
      nx = ax; ny = ay; r.st = psnd_pkg::ST_DEGEN;
    end else if (dot < 0) begin
      nx = ax; ny = ay; r.st = psnd_pkg::ST_START;
    end else if (dot > len) begin
      nx = bx; ny = by; r.st = psnd_pkg::ST_END;
    end else begin
      nx = round_axis(ax, dx, dot, len);
      ny = round_axis(ay, dy, dot, len);
      r.st = psnd_pkg::ST_INTERIOR;
    end
    ex = qx - nx; ey = qy - ny;
    r.nx = coord_t'(nx);
    r.ny = coord_t'(ny);
    r.distance = (CB + 2)'(isqrt(128'(ex * ex) + 128'(ey * ey)));
    return r;
  endfunction

  function automatic query_t mk(longint qx, qy, sx, sy, ex, ey);
    query_t q;
    q.qx = coord_t'(qx); q.qy = coord_t'(qy);
    q.sx = coord_t'(sx); q.sy = coord_t'(sy);
    q.ex = coord_t'(ex); q.ey = coord_t'(ey);
    return q;
  endfunction

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(coord_t'($urandom_range(0, 200)) - 100);
      2: return $urandom_range(0, 1)
                ? coord_t'({1'b0, {(CB-1){1'b1}}}) - coord_t'($urandom_range(0, 3))
                : coord_t'({1'b1, {(CB-1){1'b0}}}) + coord_t'($urandom_range(0, 3));
      default: return coord_t'(coord_t'($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  function automatic query_t rnd_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 3);
    q.qx = rnd_coord(mode); q.qy = rnd_coord(mode);
    q.sx = rnd_coord(mode); q.sy = rnd_coord(mode);
    q.ex = rnd_coord(mode); q.ey = rnd_coord(mode);
    case ($urandom_range(0, 15))
      0: begin q.ex = q.sx; q.ey = q.sy; end
      1: begin q.qx = q.ex; q.qy = q.ey; end
      2: begin q.qx = q.sx; q.qy = q.sy; end
      default: ;
    endcase
    return q;
  endfunction

  task automatic send(query_t q);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'(q);
    nearest_q.push_back(project_point(q));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
  endtask

  localparam coord_t MX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t MN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    row_t dir[$];
    row_t row;
    nearest_t d;
    row = '{mk(5, 5, 3, 4, 3, 4), 1, '{psnd_pkg::ST_DEGEN, 2, 4, 3}}; dir.push_back(row);
    row = '{mk(0, 0, 0, 0, 10, 0), 1, '{psnd_pkg::ST_INTERIOR, 0, 0, 0}}; dir.push_back(row);
    row = '{mk(10, 0, 0, 0, 10, 0), 1, '{psnd_pkg::ST_INTERIOR, 0, 0, 10}};
    dir.push_back(row);
    row = '{mk(-3, 4, 0, 0, 10, 0), 1, '{psnd_pkg::ST_START, 5, 0, 0}}; dir.push_back(row);
    row = '{mk(13, 4, 0, 0, 10, 0), 1, '{psnd_pkg::ST_END, 5, 0, 10}}; dir.push_back(row);
    row = '{mk(5, 7, 0, 0, 10, 0), 1, '{psnd_pkg::ST_INTERIOR, 7, 0, 5}}; dir.push_back(row);
    row = '{mk(MX, MX, MN, MN, MN, MN), 0, 'x}; dir.push_back(row);
    row = '{mk(MN, MN, MX, MX, MX, MN), 0, 'x}; dir.push_back(row);
    row = '{mk(MX, MN, MN, MN, MX, MX), 0, 'x}; dir.push_back(row);
    row = '{mk(MN, MX, MN, MN, MX, MX), 0, 'x}; dir.push_back(row);
    row = '{mk(0, 0, MN, MX, MX, MN), 0, 'x}; dir.push_back(row);
    row = '{mk(-1, 1, 0, 0, 3, 0), 0, 'x}; dir.push_back(row);
    row = '{mk(1, 1, 0, 0, 2, 1), 0, 'x}; dir.push_back(row);
    row = '{mk(-1, -2, 0, 0, -3, -1), 0, 'x}; dir.push_back(row);
    row = '{mk(-1, -1, 0, 0, 0, 0), 1, '{psnd_pkg::ST_DEGEN, 1, 0, 0}}; dir.push_back(row);
    row = '{mk(7, -9, -1, -1, 5, 7), 0, 'x}; dir.push_back(row);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    foreach (dir[i]) begin
      if (dir[i].has_exp) begin
        d = project_point(dir[i].q);
        if (d !== dir[i].r) begin
          errors++;
          $display("%0t directed row %0d: expected %h actual %h", $time, i, dir[i].r, d);
        end
        send(dir[i].q);
        nearest_q[$] = dir[i].r;
      end else begin
        send(dir[i].q);
      end
    end
    drain();
    // stall the output long enough to back up the pipeline
    hold_rx = 1'b1;
    for (int i = 0; i < 80; i++) send(rnd_query());
    drain();
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND - 300) calm = 1'b1;
      send(rnd_query());
    end
    drain();
    repeat (LAT + 20) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (3 * LAT) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        gap = $urandom_range(1, 13);
        repeat (gap) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    nearest_t got, want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.nx = m_axis_tdata[CB-1:0];
      got.ny = m_axis_tdata[2*CB-1:CB];
      got.distance = m_axis_tdata[3*CB+1:2*CB];
      got.st = m_axis_tuser;
      if (nearest_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer: actual %h", $time, got);
      end else begin
        want = nearest_q.pop_front();
        if (got.nx !== want.nx || got.ny !== want.ny) begin
          errors++;
          $display("%0t near point: expected (%0d,%0d) actual (%0d,%0d)", $time,
                   want.nx, want.ny, got.nx, got.ny);
        end
        if (got.distance !== want.distance) begin
          errors++;
          $display("%0t distance: expected %0d actual %0d", $time, want.distance,
                   got.distance);
        end
        if (got.st !== want.st) begin
          errors++;
          $display("%0t clamp status: expected %0d actual %0d", $time, want.st, got.st);
        end
      end
    end
  end

endmodule

`default_nettype wire
